### src/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request and result
// transactions, memory command bundle, kind and status codes.
// ----------------------------------------------------------------------------
package ple_pkg;

    // List storage geometry
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // Request kinds
    localparam logic [1:0] KIND_GET  = 2'd0;
    localparam logic [1:0] KIND_INS  = 2'd1;
    localparam logic [1:0] KIND_DEL  = 2'd2;
    localparam logic [1:0] KIND_SHOW = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [7:0]               position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] value_res;
        logic                     last;
    } t_res;

    // Memory port commands from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_cmd;

endpackage

### src/ple_seq.sv
// ----------------------------------------------------------------------------
// ple_seq
// Request sequencer: checks positions against the list length, walks the
// entry memory one word per cycle to open or close a gap, and drives the
// registered result transaction.
// ----------------------------------------------------------------------------
module ple_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  ple_pkg::t_req                 i_req,
    output logic                          busy,
    output logic                          o_res_valid,
    output ple_pkg::t_res                 o_res,
    output ple_pkg::t_mem_cmd             o_mem,
    input  logic [ple_pkg::WORD_W-1:0]    i_rd_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_GET     = 3'd1;
    localparam logic [2:0] S_INS_MV  = 3'd2;
    localparam logic [2:0] S_INS_PUT = 3'd3;
    localparam logic [2:0] S_DEL_GET = 3'd4;
    localparam logic [2:0] S_DEL_MV  = 3'd5;
    localparam logic [2:0] S_SHOW    = 3'd6;

    logic [2:0]                        r_state, n_state;
    logic [ple_pkg::LEN_W-1:0]         r_len, n_len;
    logic [ple_pkg::ADDR_W-1:0]        r_idx, n_idx;
    logic [ple_pkg::ADDR_W-1:0]        r_k, n_k;
    logic signed [ple_pkg::WORD_W-1:0] r_val, n_val;
    logic                              r_res_valid, n_res_valid;
    ple_pkg::t_res                     r_res, n_res;

    logic                              w_accept;
    logic [ple_pkg::ADDR_W-1:0]        w_pos_k;
    logic [7:0]                        w_len8;
    logic                              w_pos_zero;
    logic                              w_pos_in_list;
    logic                              w_pos_ins;
    logic                              w_show_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Decode the requested position against the current length
    assign w_pos_k       = ple_pkg::ADDR_W'(i_req.position - 8'd1);
    assign w_len8        = 8'(r_len);
    assign w_pos_zero    = (i_req.position == 8'd0);
    assign w_pos_in_list = !w_pos_zero && (i_req.position <= w_len8);
    assign w_pos_ins     = !w_pos_zero && (i_req.position <= w_len8 + 8'd1)
                           && (r_len < ple_pkg::CAP_LEN);
    assign w_show_last   = ((ple_pkg::LEN_W'(r_idx) + ple_pkg::LEN_W'(1)) == r_len);

    // Sequence one request over the entry memory
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_k         = r_k;
        n_val       = r_val;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_idx;
        o_mem.wdata = i_rd_data;
        o_mem.raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        ple_pkg::KIND_GET: begin
                            if (w_pos_in_list) begin
                                o_mem.raddr = w_pos_k;
                                n_state     = S_GET;
                            end else begin
                                n_res_valid = 1'b1;
                                n_res       = '{ple_pkg::ST_FAIL, '0, 1'b1};
                            end
                        end
                        ple_pkg::KIND_INS: begin
                            if (w_pos_ins) begin
                                n_k   = w_pos_k;
                                n_val = i_req.value;
                                if (i_req.position == w_len8 + 8'd1) begin
                                    n_state = S_INS_PUT;
                                end else begin
                                    o_mem.raddr = ple_pkg::ADDR_W'(r_len - ple_pkg::LEN_W'(1));
                                    n_idx       = ple_pkg::ADDR_W'(r_len);
                                    n_state     = S_INS_MV;
                                end
                            end else begin
                                n_res_valid = 1'b1;
                                n_res       = '{ple_pkg::ST_FAIL, '0, 1'b1};
                            end
                        end
                        ple_pkg::KIND_DEL: begin
                            if (w_pos_in_list) begin
                                o_mem.raddr = w_pos_k;
                                n_k         = w_pos_k;
                                n_idx       = w_pos_k;
                                n_state     = S_DEL_GET;
                            end else begin
                                n_res_valid = 1'b1;
                                n_res       = '{ple_pkg::ST_FAIL, '0, 1'b1};
                            end
                        end
                        default: begin
                            if (r_len == '0) begin
                                n_res_valid = 1'b1;
                                n_res       = '{ple_pkg::ST_EMPTY, '0, 1'b1};
                            end else begin
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SHOW;
                            end
                        end
                    endcase
                end
            end

            // Return the word read at the position
            S_GET: begin
                n_res_valid = 1'b1;
                n_res       = '{ple_pkg::ST_OK, i_rd_data, 1'b1};
                n_state     = S_IDLE;
            end

            // Move entry idx-1 up to idx, walking down toward the gap
            S_INS_MV: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rd_data;
                if (ple_pkg::ADDR_W'(r_idx - ple_pkg::ADDR_W'(1)) == r_k) begin
                    n_state = S_INS_PUT;
                end else begin
                    o_mem.raddr = ple_pkg::ADDR_W'(r_idx - ple_pkg::ADDR_W'(2));
                    n_idx       = ple_pkg::ADDR_W'(r_idx - ple_pkg::ADDR_W'(1));
                end
            end

            // Drop the new word into the gap
            S_INS_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_k;
                o_mem.wdata = r_val;
                n_len       = r_len + ple_pkg::LEN_W'(1);
                n_res_valid = 1'b1;
                n_res       = '{ple_pkg::ST_OK, '0, 1'b1};
                n_state     = S_IDLE;
            end

            // Capture the removed word, then close the gap if needed
            S_DEL_GET: begin
                n_val = i_rd_data;
                if ((ple_pkg::LEN_W'(r_k) + ple_pkg::LEN_W'(1)) == r_len) begin
                    n_len       = r_len - ple_pkg::LEN_W'(1);
                    n_res_valid = 1'b1;
                    n_res       = '{ple_pkg::ST_OK, i_rd_data, 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    o_mem.raddr = ple_pkg::ADDR_W'(r_k + ple_pkg::ADDR_W'(1));
                    n_state     = S_DEL_MV;
                end
            end

            // Move entry idx+1 down to idx
            S_DEL_MV: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rd_data;
                if ((ple_pkg::LEN_W'(r_idx) + ple_pkg::LEN_W'(2)) == r_len) begin
                    n_len       = r_len - ple_pkg::LEN_W'(1);
                    n_res_valid = 1'b1;
                    n_res       = '{ple_pkg::ST_OK, r_val, 1'b1};
                    n_state     = S_IDLE;
                end else begin
                    o_mem.raddr = ple_pkg::ADDR_W'(r_idx + ple_pkg::ADDR_W'(2));
                    n_idx       = ple_pkg::ADDR_W'(r_idx + ple_pkg::ADDR_W'(1));
                end
            end

            // Stream one entry per cycle
            S_SHOW: begin
                n_res_valid = 1'b1;
                n_res       = '{ple_pkg::ST_OK, i_rd_data, w_show_last};
                if (w_show_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_mem.raddr = ple_pkg::ADDR_W'(r_idx + ple_pkg::ADDR_W'(1));
                    n_idx       = ple_pkg::ADDR_W'(r_idx + ple_pkg::ADDR_W'(1));
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_res_valid <= n_res_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Length never exceeds the capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= ple_pkg::CAP_LEN)
        else $error("list length above capacity");

    // Insert into a full list fails on the next cycle
    a_full_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.kind == ple_pkg::KIND_INS && r_len == ple_pkg::CAP_LEN)
        |=> (r_res_valid && r_res.status == ple_pkg::ST_FAIL && r_len == ple_pkg::CAP_LEN))
        else $error("insert into full list did not fail");

    // Memory is never written while idle
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_mem.we)
        else $error("memory write while idle");

    // A move that continues never reads the entry it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INS_MV || r_state == S_DEL_MV) && n_state == r_state)
        |-> (o_mem.raddr != o_mem.waddr))
        else $error("read and write of the same entry");

    // An insert grows the list by one
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT) |=> (r_len == $past(r_len) + ple_pkg::LEN_W'(1)))
        else $error("insert did not grow the list");

endmodule

### src/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed words addressed by 1-based position, with get,
// insert, delete and show requests, held in one synchronous entry memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results come out one
// per cycle on o_res with o_res_valid high for exactly one cycle, and must be
// captured then since there is no way to hold them off. Each entry move is a
// read and a write of the single entry memory, one word per cycle. Insert
// moves the entries from the end down to position p, then writes the new word;
// delete captures the word at p, then moves the later entries down; show
// streams L results on back-to-back cycles, the last flagged, for a list of
// length L. Rejected requests and show of an empty list give their result the
// next cycle and never raise busy. Each result is registered and appears in the
// cycle after the cycle that produces it.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ple_pkg::t_req  i_req,
    output logic           busy,
    output logic           o_res_valid,
    output ple_pkg::t_res  o_res
);

    ple_pkg::t_mem_cmd              w_mem;
    logic [ple_pkg::WORD_W-1:0]     r_rd_data;
    logic [ple_pkg::WORD_W-1:0]     r_mem [ple_pkg::CAPACITY];

    // Sequence requests
    ple_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .o_mem       (w_mem),
        .i_rd_data   (r_rd_data)
    );

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem.we) begin
            r_mem[w_mem.waddr] <= w_mem.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[w_mem.raddr];
    end

endmodule

### sim/tb_positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine. A shadow list predicts
// the result transactions of every accepted get, insert, delete and show
// request. A directed opening covers the empty list, bad positions and the
// word extremes. Random traffic then fills the list to capacity and drains
// it again, with random idle cycles on the request side.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;

    localparam int N_RANDOM  = 186;
    localparam int IDLE_PCT  = 36;
    localparam int TAIL_WAIT = ple_pkg::CAPACITY + 8;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    ple_pkg::t_req  i_req;
    logic           busy;
    logic           o_res_valid;
    ple_pkg::t_res  o_res;

    positional_list_engine_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Shadow list and bookkeeping
    logic signed [ple_pkg::WORD_W-1:0] shadow_list [ple_pkg::CAPACITY];
    int   shadow_len = 0;
    ple_pkg::t_req pending_requests [$];
    ple_pkg::t_res expected_results [$];
    int   n_errors = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_rejected = 0;
    int   n_full_refused = 0;
    int   deepest_len = 0;
    int   kind_count [4] = '{default: 0};
    bit   growing;
    int   edge_tries;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Work out the result transactions of one request and update the shadow list
    task automatic predict_list_request(input ple_pkg::t_req r);
        ple_pkg::t_res res;
        int   p;
        int   i;
        begin
            p = r.position;
            res = '0;
            res.status = ple_pkg::ST_FAIL;
            res.last = 1'b1;
            kind_count[r.kind]++;
            case (r.kind)
                ple_pkg::KIND_GET: begin
                    if (p >= 1 && p <= shadow_len) begin
                        res.status = ple_pkg::ST_OK;
                        res.value_res = shadow_list[p-1];
                    end
                    expected_results.push_back(res);
                end
                ple_pkg::KIND_INS: begin
                    if (p >= 1 && p <= shadow_len + 1 && shadow_len < ple_pkg::CAPACITY) begin
                        for (i = shadow_len; i > p - 1; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[p-1] = r.value;
                        shadow_len++;
                        res.status = ple_pkg::ST_OK;
                    end else if (shadow_len == ple_pkg::CAPACITY && p >= 1 &&
                                 p <= shadow_len + 1) begin
                        n_full_refused++;
                    end
                    expected_results.push_back(res);
                end
                ple_pkg::KIND_DEL: begin
                    if (p >= 1 && p <= shadow_len) begin
                        res.status = ple_pkg::ST_OK;
                        res.value_res = shadow_list[p-1];
                        for (i = p - 1; i + 1 < shadow_len; i++)
                            shadow_list[i] = shadow_list[i+1];
                        shadow_len--;
                    end
                    expected_results.push_back(res);
                end
                default: begin
                    if (shadow_len == 0) begin
                        res.status = ple_pkg::ST_EMPTY;
                        expected_results.push_back(res);
                    end else begin
                        for (i = 0; i < shadow_len; i++) begin
                            res.status = ple_pkg::ST_OK;
                            res.value_res = shadow_list[i];
                            res.last = (i + 1 == shadow_len);
                            expected_results.push_back(res);
                        end
                    end
                end
            endcase
            if (res.status == ple_pkg::ST_FAIL)
                n_rejected++;
            if (shadow_len > deepest_len)
                deepest_len = shadow_len;
        end
    endtask

    task automatic queue_request(input logic [1:0] kind, input int pos,
                                 input logic [ple_pkg::WORD_W-1:0] word);
        ple_pkg::t_req r;
        begin
            r.kind = kind;
            r.position = pos[7:0];
            r.value = word;
            pending_requests.push_back(r);
        end
    endtask

    // Pick one random request; grow toward a full list, then drain toward empty
    task automatic queue_random_request();
        logic [1:0]                 kind;
        int                         pos;
        logic [ple_pkg::WORD_W-1:0] word;
        int                         roll;
        int                         len;
        begin
            len = shadow_len;
            roll = $urandom_range(0, 99);
            if (growing)
                kind = (roll < 70) ? ple_pkg::KIND_INS : (roll < 82) ? ple_pkg::KIND_GET :
                       (roll < 88) ? ple_pkg::KIND_DEL : ple_pkg::KIND_SHOW;
            else
                kind = (roll < 70) ? ple_pkg::KIND_DEL : (roll < 82) ? ple_pkg::KIND_GET :
                       (roll < 88) ? ple_pkg::KIND_INS : ple_pkg::KIND_SHOW;

            roll = $urandom_range(0, 99);
            if (roll < 10)
                pos = $urandom_range(0, 255);
            else if (roll < 12)
                pos = 0;
            else if (kind == ple_pkg::KIND_INS)
                pos = $urandom_range(1, len + 1);
            else
                pos = (len == 0) ? 1 : $urandom_range(1, len);

            roll = $urandom_range(0, 99);
            word = (roll < 5) ? 32'h7FFF_FFFF : (roll < 10) ? 32'h8000_0000 :
                   (roll < 13) ? 32'h0000_0000 : 32'($urandom);
            queue_request(kind, pos, word);

            // Flip direction after lingering at full or empty for a few requests
            if (growing && len == ple_pkg::CAPACITY) begin
                edge_tries++;
                if (edge_tries >= 4) begin
                    growing = 1'b0;
                    edge_tries = 0;
                end
            end else if (!growing && len == 0) begin
                edge_tries++;
                if (edge_tries >= 3) begin
                    growing = 1'b1;
                    edge_tries = 0;
                end
            end
        end
    endtask

    // Driver: present the oldest pending request, idling at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else if (pending_requests.size() == 0) begin
            start <= 1'b0;
        end else if (!(n_accepted >= 100 && n_accepted < 150) &&
                     $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
        end else begin
            start <= 1'b1;
            i_req <= pending_requests[0];
        end
    end

    // Monitor: check each result, then predict for an accepted request
    always @(posedge i_clk) begin
        ple_pkg::t_res want;
        if (i_rst_n) begin
            if (o_res_valid) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d value_res %0d last %0d",
                           o_res.status, o_res.value_res, o_res.last);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_res.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_res.status);
                        n_errors++;
                    end
                    if (o_res.value_res !== want.value_res) begin
                        $error("value_res: expected %0d, actual %0d",
                               want.value_res, o_res.value_res);
                        n_errors++;
                    end
                    if (o_res.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_res.last);
                        n_errors++;
                    end
                end
            end
            if (start && !busy) begin
                predict_list_request(i_req);
                void'(pending_requests.pop_front());
                n_accepted++;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        i_rst_n = 1'b0;
        growing = 1'b1;
        edge_tries = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list: show, bad positions, insert past the end
        queue_request(ple_pkg::KIND_SHOW, 0, 32'($urandom));
        queue_request(ple_pkg::KIND_GET, 0, 32'($urandom));
        queue_request(ple_pkg::KIND_GET, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_INS, 0, 32'h1234_5678);
        queue_request(ple_pkg::KIND_INS, 2, 32'h1234_5678);
        // Build a short list with the word extremes at front, middle and end
        queue_request(ple_pkg::KIND_INS, 1, 32'h7FFF_FFFF);
        queue_request(ple_pkg::KIND_INS, 1, 32'h8000_0000);
        queue_request(ple_pkg::KIND_INS, 3, 32'hFFFF_FFFF);
        queue_request(ple_pkg::KIND_INS, 2, 32'h0000_0000);
        queue_request(ple_pkg::KIND_INS, 6, 32'h5555_AAAA);
        queue_request(ple_pkg::KIND_GET, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_GET, 4, 32'($urandom));
        queue_request(ple_pkg::KIND_GET, 5, 32'($urandom));
        queue_request(ple_pkg::KIND_GET, 255, 32'($urandom));
        queue_request(ple_pkg::KIND_SHOW, 255, 32'($urandom));
        // Drain it: middle, end, bad positions, front
        queue_request(ple_pkg::KIND_DEL, 2, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 3, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 0, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 3, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_SHOW, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_DEL, 1, 32'($urandom));
        queue_request(ple_pkg::KIND_SHOW, 7, 32'($urandom));

        // Random traffic, generated close to the shadow list's current length
        for (int k = 0; k < N_RANDOM; k++) begin
            while (pending_requests.size() >= 2)
                @(posedge i_clk);
            queue_random_request();
        end

        // Drain, then watch for stray results
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d requests (get %0d, insert %0d, delete %0d, show %0d), %0d results",
                 n_accepted, kind_count[ple_pkg::KIND_GET], kind_count[ple_pkg::KIND_INS],
                 kind_count[ple_pkg::KIND_DEL], kind_count[ple_pkg::KIND_SHOW], n_results);
        $display("rejected %0d, deepest list %0d of %0d, inserts refused on full list %0d",
                 n_rejected, deepest_len, ple_pkg::CAPACITY, n_full_refused);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
